// ----- hdl/lbpg_pkg.sv -----
package lbpg_pkg;

  // Command codes carried by each request.
  localparam logic [1:0] CMD_UPDATE   = 2'd0;
  localparam logic [1:0] CMD_SET_MODE = 2'd1;
  localparam logic [1:0] CMD_SET_LOCK = 2'd2;

  // LED modes.
  localparam logic [2:0] MODE_OFF    = 3'd0;
  localparam logic [2:0] MODE_ON     = 3'd1;
  localparam logic [2:0] MODE_SLOW   = 3'd2;
  localparam logic [2:0] MODE_FAST   = 3'd3;
  localparam logic [2:0] MODE_DOUBLE = 3'd4;
  localparam logic [2:0] MODE_TRIPLE = 3'd5;

  // Configuration register map (register index = paddr[3:2]).
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;
  localparam logic [1:0] REG_SLOW   = 2'd0;
  localparam logic [1:0] REG_FAST   = 2'd1;
  localparam logic [1:0] REG_DOUBLE = 2'd2;
  localparam logic [1:0] REG_TRIPLE = 2'd3;

  localparam logic [15:0] SLOW_RESET   = 16'd1000;
  localparam logic [15:0] FAST_RESET   = 16'd200;
  localparam logic [15:0] DOUBLE_RESET = 16'd200;
  localparam logic [15:0] TRIPLE_RESET = 16'd150;

  typedef struct packed {
    logic [15:0] slow;
    logic [15:0] fast;
    logic [15:0] dbl;
    logic [15:0] tpl;
  } period_cfg_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [3:0] step;
    logic       toggle;
    logic       drive;
    logic       lock;
  } pat_state_t;

endpackage

// ----- hdl/lbpg_step.sv -----
module lbpg_step #(
  parameter int unsigned TIME_WIDTH = 16
) (
  input  logic [1:0]              cmd_i,
  input  logic [15:0]             ms_passed_i,
  input  logic [2:0]              new_mode_i,
  input  logic                    lock_flag_i,
  input  lbpg_pkg::period_cfg_t   cfg_i,
  input  lbpg_pkg::pat_state_t    state_i,
  input  logic [TIME_WIDTH-1:0]   elapsed_i,
  output lbpg_pkg::pat_state_t    state_o,
  output logic [TIME_WIDTH-1:0]   elapsed_o
);

  localparam int unsigned CmpW = (TIME_WIDTH > 16) ? TIME_WIDTH : 16;
  localparam int unsigned SumW = CmpW + 1;

  logic [SumW-1:0]       sum;
  logic [TIME_WIDTH-1:0] sat;
  logic [CmpW-1:0]       period;
  logic                  expired;
  logic [3:0]            step_inc;
  lbpg_pkg::pat_state_t  st;
  logic [TIME_WIDTH-1:0] el;

  // The elapsed count saturates instead of wrapping.
  assign sum = SumW'(elapsed_i) + SumW'(ms_passed_i);
  assign sat = (|sum[SumW-1:TIME_WIDTH]) ? {TIME_WIDTH{1'b1}} : sum[TIME_WIDTH-1:0];

  always_comb begin
    case (state_i.mode)
      lbpg_pkg::MODE_SLOW:   period = CmpW'(cfg_i.slow);
      lbpg_pkg::MODE_FAST:   period = CmpW'(cfg_i.fast);
      lbpg_pkg::MODE_DOUBLE: period = CmpW'(cfg_i.dbl);
      lbpg_pkg::MODE_TRIPLE: period = CmpW'(cfg_i.tpl);
      default:               period = '0;
    endcase
  end

  assign expired  = CmpW'(sat) >= period;
  assign step_inc = state_i.step + 4'd1;

  always_comb begin
    st = state_i;
    el = sat;
    case (cmd_i)
      lbpg_pkg::CMD_UPDATE: begin
        case (state_i.mode)
          lbpg_pkg::MODE_OFF: st.drive = 1'b0;
          lbpg_pkg::MODE_ON:  st.drive = 1'b1;
          lbpg_pkg::MODE_SLOW, lbpg_pkg::MODE_FAST: begin
            if (expired) begin
              st.toggle = ~state_i.toggle;
              st.drive  = ~state_i.toggle;
              el        = '0;
            end
          end
          lbpg_pkg::MODE_DOUBLE: begin
            if (expired) begin
              st.step = step_inc;
              el      = '0;
              if (step_inc inside {4'd1, 4'd3}) begin
                st.drive = 1'b1;
              end else if (step_inc inside {4'd2, 4'd4}) begin
                st.drive = 1'b0;
              end else if (step_inc >= 4'd6) begin
                st.step = 4'd0;
              end
            end
          end
          lbpg_pkg::MODE_TRIPLE: begin
            if (expired) begin
              st.step = step_inc;
              el      = '0;
              if (step_inc[0] && step_inc <= 4'd5) begin
                st.drive = 1'b1;
              end else if (!step_inc[0] && step_inc <= 4'd6) begin
                st.drive = 1'b0;
              end else if (step_inc >= 4'd8) begin
                st.step = 4'd0;
              end
            end
          end
          default: ;
        endcase
      end
      lbpg_pkg::CMD_SET_MODE: begin
        // A mode change restarts the pattern unless locked; the mode command itself leaves the LED level as it is.
        if (new_mode_i != state_i.mode && !state_i.lock) begin
          st.mode = new_mode_i;
          st.step = 4'd0;
          el      = '0;
        end
      end
      lbpg_pkg::CMD_SET_LOCK: st.lock = lock_flag_i;
      default: ;
    endcase
  end

  assign state_o   = st;
  assign elapsed_o = el;

endmodule

// ----- hdl/led_blink_pattern_generator_core.sv -----
// LED blink pattern generator.
// Requests arrive on the input channel (in_valid_i / in_stall_o) with a command,
// the milliseconds passed since the previous request, a requested mode and a
// lock flag. Each accepted request updates the pattern state and produces exactly
// one result (LED level, mode in effect, lock flag) on the output channel
// (out_valid_o / out_stall_i).
// The result of an accepted request is registered. Throughput is one request per
// cycle while in_stall_o is low; the whole state update is a single pass of
// compare and step logic feeding the state registers.
// When the receiver stalls, one further request is taken into a skid register;
// after that in_stall_o rises until the output drains.
// Reset clears the pattern state to mode off, LED off, unlocked, and loads the
// default intervals (1000, 200, 200, 150 ms). Write the intervals through the APB
// port at byte addresses 0, 4, 8 and 12 while the block is idle; it is not enforced.
module led_blink_pattern_generator_core #(
  parameter int unsigned TIME_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    cmd_i,
  input  logic [15:0]                   ms_passed_i,
  input  logic [2:0]                    new_mode_i,
  input  logic                          lock_flag_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          led_on_o,
  output logic [2:0]                    mode_now_o,
  output logic                          is_locked_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lbpg_pkg::ADDR_W-1:0]   paddr,
  input  logic [lbpg_pkg::DATA_W-1:0]   pwdata,
  output logic [lbpg_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  lbpg_pkg::period_cfg_t cfg_q;
  lbpg_pkg::pat_state_t  state_q, state_d;
  logic [TIME_WIDTH-1:0] elapsed_q, elapsed_d;
  logic                  cfg_wr;
  logic [1:0]            reg_idx;
  logic                  in_acc;
  logic                  out_busy;
  logic                  out_vld_q, skid_vld_q;
  logic [4:0]            out_q, skid_q, res;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slow <= lbpg_pkg::SLOW_RESET;
      cfg_q.fast <= lbpg_pkg::FAST_RESET;
      cfg_q.dbl  <= lbpg_pkg::DOUBLE_RESET;
      cfg_q.tpl  <= lbpg_pkg::TRIPLE_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        lbpg_pkg::REG_SLOW:   cfg_q.slow <= pwdata[15:0];
        lbpg_pkg::REG_FAST:   cfg_q.fast <= pwdata[15:0];
        lbpg_pkg::REG_DOUBLE: cfg_q.dbl  <= pwdata[15:0];
        lbpg_pkg::REG_TRIPLE: cfg_q.tpl  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      lbpg_pkg::REG_SLOW:   prdata = lbpg_pkg::DATA_W'(cfg_q.slow);
      lbpg_pkg::REG_FAST:   prdata = lbpg_pkg::DATA_W'(cfg_q.fast);
      lbpg_pkg::REG_DOUBLE: prdata = lbpg_pkg::DATA_W'(cfg_q.dbl);
      lbpg_pkg::REG_TRIPLE: prdata = lbpg_pkg::DATA_W'(cfg_q.tpl);
      default:              prdata = '0;
    endcase
  end

  // ---------------- pattern state ----------------
  assign in_stall_o = skid_vld_q;
  assign in_acc     = in_valid_i && !skid_vld_q;

  lbpg_step #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_step (
    .cmd_i       (cmd_i),
    .ms_passed_i (ms_passed_i),
    .new_mode_i  (new_mode_i),
    .lock_flag_i (lock_flag_i),
    .cfg_i       (cfg_q),
    .state_i     (state_q),
    .elapsed_i   (elapsed_q),
    .state_o     (state_d),
    .elapsed_o   (elapsed_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= '0;
      elapsed_q <= '0;
    end else if (in_acc) begin
      state_q   <= state_d;
      elapsed_q <= elapsed_d;
    end
  end

  // Result fields packed as {drive, mode, lock}.
  assign res = {state_d.drive, state_d.mode, state_d.lock};

  // ---------------- output register and skid stage ----------------
  assign out_busy = out_vld_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_busy) begin
      if (in_acc) begin
        skid_vld_q <= 1'b1;
      end
    end else if (skid_vld_q) begin
      out_vld_q  <= 1'b1;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_busy) begin
      if (in_acc) begin
        skid_q <= res;
      end
    end else if (skid_vld_q) begin
      out_q <= skid_q;
    end else if (in_acc) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign led_on_o    = out_q[4];
  assign mode_now_o  = out_q[3:1];
  assign is_locked_o = out_q[0];

  // ---------------- assertions ----------------
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid register holds a result while the output register is empty");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !out_busy) |=> (out_vld_q && !skid_vld_q))
    else $error("accepted request did not reach the output register");

  a_mode_change_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && cmd_i == lbpg_pkg::CMD_SET_MODE && !state_q.lock
      && new_mode_i != state_q.mode)
    |=> (elapsed_q == '0 && state_q.step == 4'd0))
    else $error("mode change did not restart the pattern");

  a_lock_holds_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && state_q.lock && cmd_i != lbpg_pkg::CMD_SET_LOCK)
    |=> $stable(state_q.mode))
    else $error("mode changed while locked");

endmodule
